[rtl/core/dpf_pkg.sv]
// Shared types and constants for the de-duplicating packet FIFO.
// Used by the compare cell and by the top level; depends on nothing.
package dpf_pkg;

    localparam int OP_W      = 2;
    localparam int ID_W      = 16;
    localparam int STAMP_W   = 32;
    localparam int COUNT_W   = 7;
    localparam int LIMIT_W   = 7;

    localparam logic [OP_W-1:0]    OP_ADD     = 2'd0;
    localparam logic [OP_W-1:0]    OP_FORWARD = 2'd1;
    localparam logic [OP_W-1:0]    OP_COUNT   = 2'd2;
    localparam logic [OP_W-1:0]    OP_NOP     = 2'd3;

    localparam logic [COUNT_W-1:0] COUNT_MAX   = 7'd127;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

    typedef struct packed {
        logic [ID_W-1:0]    src;
        logic [ID_W-1:0]    dst;
        logic [STAMP_W-1:0] stamp;
    } entry_t;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [ID_W-1:0]    src;
        logic [ID_W-1:0]    dst;
        logic [STAMP_W-1:0] stamp;
        logic [STAMP_W-1:0] lo;
        logic [STAMP_W-1:0] hi;
    } req_t;

    // Partial result that ripples down the chain, one cell per cycle.
    typedef struct packed {
        logic               dup;
        logic [COUNT_W-1:0] cnt;
    } scan_t;

    // Per-cell update command issued on the commit cycle.
    typedef struct packed {
        logic shift;
        logic load;
    } cell_ctrl_t;

endpackage

[rtl/core/dedup_packet_fifo_range_count.sv]
// Top level of the de-duplicating packet FIFO with range counter.
// Depends on dpf_pkg and instantiates DEPTH dpf_cell compare cells.
//
// Packets are kept oldest-first in a chain of DEPTH cells; a forward or an
// eviction shifts every cell one place toward the head, and an add loads the
// cell just past the youngest. The request is held in a register while a
// duplicate flag and a match count ripple through the chain, one cell per
// cycle; once the last cell reports and the output register can take a beat,
// the chain is updated and the result is loaded into the output register.
// The input is free again after that update, so a new request is taken only
// once the previous one has committed. A result that is stalled does not
// block the next input beat, but that request's update waits until the
// output register frees up. Every request, including forward and the unused
// op code, runs the full scan.
// The configured limit is clamped into 1..DEPTH; lowering it below the
// current fill only makes each later add evict one entry. Configuration is
// taken at any time but must only be written while the block is idle. The
// count saturates at 127 for large DEPTH.
module dedup_packet_fifo_range_count #(
    parameter int DEPTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [6:0]  capacity_limit,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  op,
    input  logic [15:0] src_id,
    input  logic [15:0] dst_id,
    input  logic [31:0] stamp,
    input  logic [31:0] range_start,
    input  logic [31:0] range_end,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        added,
    output logic        popped_valid,
    output logic [15:0] popped_src,
    output logic [15:0] popped_dst,
    output logic [31:0] popped_stamp,
    output logic [6:0]  match_count
);
    import dpf_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int LW    = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    // Control state.
    logic               state_reg;
    logic               state_next;
    logic [CNT_W-1:0]   step_reg;
    logic [CNT_W-1:0]   step_next;
    logic [CNT_W-1:0]   occ_reg;
    logic [CNT_W-1:0]   occ_next;
    logic [LIMIT_W-1:0] limit_reg;
    req_t               req_reg;

    // Output register.
    logic               out_valid_reg;
    logic               added_reg;
    logic               popped_valid_reg;
    entry_t             popped_reg;
    logic [COUNT_W-1:0] match_reg;

    // Chain wiring: scan_w[0] feeds the head cell, scan_w[DEPTH] is the result.
    entry_t             ent_w  [DEPTH];
    scan_t              scan_w [DEPTH+1];
    cell_ctrl_t         ctrl_w [DEPTH];

    logic               in_fire;
    logic               scan_done;
    logic               commit;
    logic               do_add;
    logic               do_pop;
    logic               evict;
    logic               shift;
    logic [CNT_W-1:0]   wpos;
    logic [LW-1:0]      lim_ext;
    logic [LW-1:0]      eff_lim;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_fire   = in_valid && !in_stall;

    // The final cell has folded in its compare once the step count reaches DEPTH.
    assign scan_done = (state_reg == ST_SCAN) && (step_reg == CNT_W'(DEPTH));
    assign commit    = scan_done && (!out_valid_reg || !out_stall);

    // Limit of zero acts as one; anything above DEPTH acts as DEPTH.
    assign lim_ext = LW'(limit_reg);
    always_comb
    begin
        if (limit_reg == '0)
        begin
            eff_lim = LW'(1);
        end
        else if (lim_ext > LW'(DEPTH))
        begin
            eff_lim = LW'(DEPTH);
        end
        else
        begin
            eff_lim = lim_ext;
        end
    end

    assign evict  = (LW'(occ_reg) >= eff_lim);
    assign do_add = commit && (req_reg.op == OP_ADD) && !scan_w[DEPTH].dup;
    assign do_pop = commit && (req_reg.op == OP_FORWARD) && (occ_reg != '0);
    assign shift  = do_pop || (do_add && evict);
    // With an eviction the tail moves down one place before the new packet lands.
    assign wpos   = evict ? (occ_reg - CNT_W'(1)) : occ_reg;

    always_comb
    begin
        occ_next = occ_reg;
        if (do_add && !evict)
        begin
            occ_next = occ_reg + CNT_W'(1);
        end
        else if (do_pop)
        begin
            occ_next = occ_reg - CNT_W'(1);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = ST_SCAN;
                    step_next  = '0;
                end
            end
            ST_SCAN:
            begin
                if (commit)
                begin
                    state_next = ST_IDLE;
                end
                else if (!scan_done)
                begin
                    step_next = step_reg + CNT_W'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            occ_reg   <= '0;
            limit_reg <= LIMIT_RESET;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            occ_reg   <= occ_next;
            if (cfg_valid && cfg_ready)
            begin
                limit_reg <= capacity_limit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            req_reg <= '{op: op, src: src_id, dst: dst_id, stamp: stamp,
                         lo: range_start, hi: range_end};
        end
    end

    // Result beat: fields that the request does not produce read as zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            added_reg        <= do_add;
            popped_valid_reg <= do_pop;
            popped_reg       <= do_pop ? ent_w[0] : '0;
            match_reg        <= (req_reg.op == OP_COUNT) ? scan_w[DEPTH].cnt : '0;
        end
    end

    assign scan_w[0] = '0;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        entry_t nbr;

        if (i == DEPTH - 1)
        begin : g_tail
            assign nbr = ent_w[i];
        end
        else
        begin : g_body
            assign nbr = ent_w[i+1];
        end

        assign ctrl_w[i].shift = shift;
        assign ctrl_w[i].load  = do_add && (wpos == CNT_W'(i));

        dpf_cell #(
            .IDX   (i),
            .CNT_W (CNT_W)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .occ        (occ_reg),
            .req        (req_reg),
            .ctrl       (ctrl_w[i]),
            .next_entry (nbr),
            .scan_in    (scan_w[i]),
            .entry      (ent_w[i]),
            .scan_out   (scan_w[i+1])
        );
    end

    assign out_valid    = out_valid_reg;
    assign added        = added_reg;
    assign popped_valid = popped_valid_reg;
    assign popped_src   = popped_reg.src;
    assign popped_dst   = popped_reg.dst;
    assign popped_stamp = popped_reg.stamp;
    assign match_count  = match_reg;

endmodule

[rtl/core/dpf_cell.sv]
// One storage and compare cell of the packet chain.
// Depends on dpf_pkg for the entry, request, scan and control types.
module dpf_cell #(
    parameter int IDX   = 0,
    parameter int CNT_W = 7
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [CNT_W-1:0]       occ,
    input  dpf_pkg::req_t          req,
    input  dpf_pkg::cell_ctrl_t    ctrl,
    input  dpf_pkg::entry_t        next_entry,
    input  dpf_pkg::scan_t         scan_in,
    output dpf_pkg::entry_t        entry,
    output dpf_pkg::scan_t         scan_out
);
    import dpf_pkg::*;

    entry_t entry_reg;
    scan_t  scan_reg;
    scan_t  scan_next;
    logic   held;
    logic   dup_hit;
    logic   cnt_hit;

    // The cell holds a packet when its position is below the occupancy.
    assign held    = (CNT_W'(IDX) < occ);
    assign dup_hit = held && (entry_reg.src == req.src) && (entry_reg.dst == req.dst)
                     && (entry_reg.stamp == req.stamp);
    assign cnt_hit = held && (entry_reg.dst == req.dst)
                     && (entry_reg.stamp >= req.lo) && (entry_reg.stamp <= req.hi);

    always_comb
    begin
        scan_next.dup = scan_in.dup | dup_hit;
        if (scan_in.cnt == COUNT_MAX)
        begin
            scan_next.cnt = COUNT_MAX;
        end
        else
        begin
            scan_next.cnt = scan_in.cnt + COUNT_W'(cnt_hit);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            entry_reg <= '{src: req.src, dst: req.dst, stamp: req.stamp};
        end
        else if (ctrl.shift)
        begin
            entry_reg <= next_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_reg <= '0;
        end
        else
        begin
            scan_reg <= scan_next;
        end
    end

    assign entry    = entry_reg;
    assign scan_out = scan_reg;

endmodule

[rtl/core/dpf_checker.sv]
// Port-level checks for the de-duplicating packet FIFO, bound to the top level.
// Depends only on the top level's ports.
module dpf_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic        added,
    input logic        popped_valid,
    input logic [15:0] popped_src,
    input logic [15:0] popped_dst,
    input logic [31:0] popped_stamp,
    input logic [6:0]  match_count
);

    // A result beat held by a stall stays valid and keeps its flags, stamp and count.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(added) && $stable(popped_valid)
        && $stable(popped_stamp) && $stable(match_count))
        else $error("stalled result beat changed");

    // An accepted request keeps the input side busy on the next cycle.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken again before the scan ran");

    // A beat reports at most one kind of result.
    a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(added && popped_valid))
        else $error("add and forward flagged together");

    // Without a forwarded packet the packet fields read as zero.
    a_pop_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !popped_valid |-> popped_src == 16'd0 && popped_dst == 16'd0
        && popped_stamp == 32'd0)
        else $error("packet fields set without a forwarded packet");

    // An add or forward result carries no count.
    a_cnt_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (added || popped_valid) |-> match_count == 7'd0)
        else $error("count set on an add or forward result");

endmodule

bind dedup_packet_fifo_range_count dpf_checker u_dpf_checker (.*);

[tb/tb_top.sv]
// Self-checking testbench for the de-duplicating packet FIFO with range counter.
// Depends on dpf_pkg and on the dedup_packet_fifo_range_count top level.
// Random and directed requests are checked beat by beat against a queue-based predictor.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import dpf_pkg::*;

    localparam int DEPTH       = 64;
    // The watchdog limit is set well above what a correct run needs.
    localparam int CYCLE_LIMIT = 1_500_000;
    localparam int CHUNK       = 100;
    localparam int NUM_PHASES  = 8;

    // One result beat as the block presents it.
    typedef struct packed {
        logic               added;
        logic               popped_valid;
        logic [ID_W-1:0]    popped_src;
        logic [ID_W-1:0]    popped_dst;
        logic [STAMP_W-1:0] popped_stamp;
        logic [COUNT_W-1:0] match_count;
    } pkt_result_t;

    logic clk = 1'b0;
    logic rst_n;

    logic               cfg_valid;
    logic               cfg_ready;
    logic [LIMIT_W-1:0] cfg_limit;

    logic               in_valid;
    logic               in_stall;
    req_t               cur_req;

    logic               out_valid;
    logic               out_stall;
    logic               added;
    logic               popped_valid;
    logic [ID_W-1:0]    popped_src;
    logic [ID_W-1:0]    popped_dst;
    logic [STAMP_W-1:0] popped_stamp;
    logic [COUNT_W-1:0] match_count;

    // Requests waiting for the driver, and results the predictor has produced but the
    // block has not yet delivered.
    req_t        pending_reqs[$];
    pkt_result_t expected_results[$];

    // Predictor state: the held packets oldest first, plus the raw limit register.
    entry_t             held_pkts[$];
    logic [LIMIT_W-1:0] limit_reg;

    // Idle percentages of the current phase, read by the driver every cycle.
    int unsigned gap_pct;
    int unsigned stall_pct;

    int  err_count;
    int  cycles;
    // Set at each rising edge when the input beat on the pins was accepted.
    bit  in_taken;

    always #5 clk = ~clk;

    dedup_packet_fifo_range_count #(
        .DEPTH(DEPTH)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .capacity_limit(cfg_limit),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .op            (cur_req.op),
        .src_id        (cur_req.src),
        .dst_id        (cur_req.dst),
        .stamp         (cur_req.stamp),
        .range_start   (cur_req.lo),
        .range_end     (cur_req.hi),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .added         (added),
        .popped_valid  (popped_valid),
        .popped_src    (popped_src),
        .popped_dst    (popped_dst),
        .popped_stamp  (popped_stamp),
        .match_count   (match_count)
    );

    // The limit register is clamped into 1..DEPTH before use.
    function automatic int active_limit();
        int lim;
        lim = int'(limit_reg);
        if (lim == 0)
        begin
            lim = 1;
        end
        if (lim > DEPTH)
        begin
            lim = DEPTH;
        end
        return lim;
    endfunction

    // Applies one request to the held packets and returns the result it must produce.
    function automatic pkt_result_t fifo_predict(input req_t rq);
        pkt_result_t res;
        entry_t      ent;
        bit          dup;
        int          hits;
        res = '0;
        case (rq.op)
            OP_ADD:
            begin
                dup = 1'b0;
                foreach (held_pkts[i])
                begin
                    if (held_pkts[i].src == rq.src && held_pkts[i].dst == rq.dst &&
                        held_pkts[i].stamp == rq.stamp)
                    begin
                        dup = 1'b1;
                    end
                end
                // A rejected duplicate never evicts, even when the FIFO is full.
                if (!dup)
                begin
                    if (held_pkts.size() >= active_limit())
                    begin
                        held_pkts.delete(0);
                    end
                    ent.src   = rq.src;
                    ent.dst   = rq.dst;
                    ent.stamp = rq.stamp;
                    held_pkts.insert(held_pkts.size(), ent);
                    res.added = 1'b1;
                end
            end
            OP_FORWARD:
            begin
                if (held_pkts.size() > 0)
                begin
                    ent = held_pkts[0];
                    held_pkts.delete(0);
                    res.popped_valid = 1'b1;
                    res.popped_src   = ent.src;
                    res.popped_dst   = ent.dst;
                    res.popped_stamp = ent.stamp;
                end
            end
            OP_COUNT:
            begin
                // A reversed range matches nothing, which falls out of the two compares.
                hits = 0;
                foreach (held_pkts[i])
                begin
                    if (held_pkts[i].dst == rq.dst && held_pkts[i].stamp >= rq.lo &&
                        held_pkts[i].stamp <= rq.hi)
                    begin
                        hits++;
                    end
                end
                res.match_count = (hits > int'(COUNT_MAX)) ? COUNT_MAX : COUNT_W'(hits);
            end
            default:
            begin
                // The unused op code leaves the state alone and returns all zeros.
            end
        endcase
        return res;
    endfunction

    task automatic report_mismatch(input string what, input pkt_result_t want,
                                   input pkt_result_t got);
        err_count++;
        if (err_count <= 10)
        begin
            $display("[%0t] %s: want add=%0d pv=%0d src=%h dst=%h stamp=%h cnt=%0d",
                     $time, what, want.added, want.popped_valid, want.popped_src,
                     want.popped_dst, want.popped_stamp, want.match_count);
            $display("[%0t] %s:  got add=%0d pv=%0d src=%h dst=%h stamp=%h cnt=%0d",
                     $time, what, got.added, got.popped_valid, got.popped_src,
                     got.popped_dst, got.popped_stamp, got.match_count);
        end
    endtask

    task automatic push_req(input logic [OP_W-1:0] kind, input logic [ID_W-1:0] src,
                            input logic [ID_W-1:0] dst, input logic [STAMP_W-1:0] stm,
                            input logic [STAMP_W-1:0] lo, input logic [STAMP_W-1:0] hi);
        req_t rq;
        rq.op    = kind;
        rq.src   = src;
        rq.dst   = dst;
        rq.stamp = stm;
        rq.lo    = lo;
        rq.hi    = hi;
        pending_reqs.insert(pending_reqs.size(), rq);
    endtask

    // Random request. Identifiers and stamps come mostly from small pools so that
    // duplicates and count hits are frequent; the rest are full-width values.
    task automatic push_random_req();
        logic [OP_W-1:0]    kind;
        logic [ID_W-1:0]    src;
        logic [ID_W-1:0]    dst;
        logic [STAMP_W-1:0] stm;
        logic [STAMP_W-1:0] lo;
        logic [STAMP_W-1:0] hi;
        int unsigned        pick;
        pick = $urandom_range(0, 99);
        if (pick < 50)
        begin
            kind = OP_ADD;
        end
        else if (pick < 70)
        begin
            kind = OP_FORWARD;
        end
        else if (pick < 95)
        begin
            kind = OP_COUNT;
        end
        else
        begin
            kind = OP_NOP;
        end
        src = ($urandom_range(0, 99) < 80) ? ID_W'($urandom_range(0, 3)) : ID_W'($urandom);
        dst = ($urandom_range(0, 99) < 80) ? ID_W'($urandom_range(0, 3)) : ID_W'($urandom);
        stm = ($urandom_range(0, 99) < 70) ? STAMP_W'($urandom_range(0, 15)) : $urandom;
        pick = $urandom_range(0, 99);
        if (pick < 60)
        begin
            lo = $urandom_range(0, 15);
            hi = $urandom_range(0, 15);
        end
        else if (pick < 75)
        begin
            lo = '0;
            hi = '1;
        end
        else
        begin
            lo = $urandom;
            hi = $urandom;
        end
        push_req(kind, src, dst, stm, lo, hi);
    endtask

    // Holds the sender back until every request has gone in and every result is out.
    task automatic wait_drained();
        do
        begin
            @(posedge clk);
        end
        while (pending_reqs.size() != 0 || in_valid || expected_results.size() != 0);
    endtask

    // Writes the limit register; the block is idle whenever this is called.
    task automatic write_limit(input logic [LIMIT_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_limit <= value;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        limit_reg = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Driver: a beat that is not yet accepted is held unchanged. Otherwise the next
    // request is presented, unless the phase asks for an idle cycle here.
    always @(negedge clk)
    begin
        if (!(in_valid && !in_taken))
        begin
            if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= gap_pct)
            begin
                cur_req  <= pending_reqs[0];
                pending_reqs.delete(0);
                in_valid <= 1'b1;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
        out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // Monitor: checks the result beat first, then predicts for the input beat taken
    // on the same edge. The two never belong to one request since the latency is long.
    always @(posedge clk)
    begin
        pkt_result_t got;
        pkt_result_t want;
        in_taken = 1'b0;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                got.added        = added;
                got.popped_valid = popped_valid;
                got.popped_src   = popped_src;
                got.popped_dst   = popped_dst;
                got.popped_stamp = popped_stamp;
                got.match_count  = match_count;
                if (expected_results.size() == 0)
                begin
                    report_mismatch("unexpected result beat", '0, got);
                end
                else
                begin
                    want = expected_results[0];
                    expected_results.delete(0);
                    if (got.added !== want.added || got.popped_valid !== want.popped_valid ||
                        got.popped_src !== want.popped_src ||
                        got.popped_dst !== want.popped_dst ||
                        got.popped_stamp !== want.popped_stamp ||
                        got.match_count !== want.match_count)
                    begin
                        report_mismatch("result field differs", want, got);
                    end
                end
            end
            in_taken = in_valid && !in_stall;
            if (in_taken)
            begin
                expected_results.insert(expected_results.size(), fifo_predict(cur_req));
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        logic [LIMIT_W-1:0] phase_limits[NUM_PHASES];
        int unsigned        phase_gap[4];
        int unsigned        phase_stall[4];

        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_limit = LIMIT_RESET;
        in_valid  = 1'b0;
        cur_req   = '0;
        out_stall = 1'b0;
        gap_pct   = 0;
        stall_pct = 0;
        err_count = 0;
        cycles    = 0;
        limit_reg = LIMIT_RESET;

        // Idle profiles: none, sender mostly idle, receiver mostly stalling, both a little.
        phase_gap   = '{0, 75, 0, 20};
        phase_stall = '{0, 0, 75, 20};
        // Limits include both clamped extremes, the exact bounds and a random pick.
        phase_limits = '{7'd64, 7'd127, 7'd1, 7'd65, 7'd4, 7'd0, 7'd16,
                         LIMIT_W'($urandom_range(0, 127))};

        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        // Directed part at the reset limit: empty forward and count, duplicate add,
        // full-width fields, full, reversed and single-point ranges, and the unused op.
        push_req(OP_FORWARD, '0, '0, '0, '0, '0);
        push_req(OP_COUNT, '0, '0, '0, '0, '1);
        push_req(OP_ADD, '0, '0, '0, '0, '0);
        push_req(OP_ADD, '0, '0, '0, '0, '0);
        push_req(OP_ADD, '1, '1, '1, '1, '1);
        push_req(OP_ADD, '0, '1, '0, '0, '0);
        push_req(OP_COUNT, '0, '1, '0, '0, '1);
        push_req(OP_COUNT, '0, '1, '0, '1, '0);
        push_req(OP_COUNT, '0, '1, '0, '1, '1);
        push_req(OP_NOP, '1, '1, '1, '1, '1);
        push_req(OP_FORWARD, '1, '1, '1, '1, '1);
        wait_drained();

        // Two packets are held and the limit drops to two: re-adding the oldest one
        // must be rejected without an eviction, while a new packet evicts it.
        write_limit(7'd2);
        push_req(OP_ADD, '1, '1, '1, '0, '0);
        push_req(OP_ADD, 16'd1, 16'd2, 32'd3, '0, '0);
        push_req(OP_COUNT, '0, 16'd2, '0, 32'd3, 32'd3);
        wait_drained();

        // A zero limit behaves as one, and it sits below the current fill of two:
        // each add evicts only one entry, and the forwards then empty the FIFO.
        write_limit(7'd0);
        push_req(OP_ADD, 16'd5, 16'd6, 32'd7, '0, '0);
        push_req(OP_FORWARD, '0, '0, '0, '0, '0);
        push_req(OP_FORWARD, '0, '0, '0, '0, '0);
        push_req(OP_FORWARD, '0, '0, '0, '0, '0);
        push_req(OP_ADD, 16'd9, 16'd9, 32'd9, '0, '0);
        push_req(OP_ADD, 16'd10, 16'd10, 32'd10, '0, '0);
        wait_drained();

        // Random phases. Each one drains halfway so the sender sits out a full drain,
        // and held packets carry over, so a lower limit often lands below the fill.
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            gap_pct   = phase_gap[p % 4];
            stall_pct = phase_stall[p % 4];
            write_limit(phase_limits[p]);
            for (int half = 0; half < 2; half++)
            begin
                repeat (CHUNK) push_random_req();
                wait_drained();
            end
        end

        // Quiet tail: any result beyond the expected ones would surface here.
        gap_pct   = 0;
        stall_pct = 0;
        repeat (DEPTH + 16) @(posedge clk);
        while (expected_results.size() != 0)
        begin
            report_mismatch("missing result beat", expected_results[0], '0);
            expected_results.delete(0);
        end

        if (err_count == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

[files.f]
rtl/core/dpf_pkg.sv
rtl/core/dpf_cell.sv
rtl/core/dedup_packet_fifo_range_count.sv
rtl/core/dpf_checker.sv
tb/tb_top.sv
